// ===== rtl/itoa_pkg.sv =====
package itoa_pkg;

    // request modes as they arrive on the input channel
    localparam logic [1:0] MODE_LITERAL  = 2'd0;
    localparam logic [1:0] MODE_SIGNED   = 2'd1;
    localparam logic [1:0] MODE_UNSIGNED = 2'd2;
    localparam logic [1:0] MODE_HEX      = 2'd3;

    // field widths
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;

    // decimal digits of a 32-bit magnitude, four bits of input per conversion step
    localparam int unsigned NUM_DIGITS  = 10;
    localparam int unsigned BCD_W       = NUM_DIGITS * 4;
    localparam int unsigned BITS_STEP   = 4;
    localparam int unsigned CONV_STEPS  = VALUE_W / BITS_STEP;

    // default depth of the request queue
    localparam int unsigned QUEUE_DEPTH = 2;

    // characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;

    // what the back end has to do with a request
    typedef enum logic [1:0] {
        K_LIT,
        K_DEC,
        K_HEX
    } kind_t;

    // classified request handed from front to back
    typedef struct packed {
        kind_t               kind;
        logic                neg;
        logic [VALUE_W-1:0]  mag;
        logic [CHAR_W-1:0]   ch;
    } fmt_req_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_CONV,
        B_SCAN,
        B_PRE,
        B_DIG,
        B_LIT
    } back_state_t;

    // digit value to uppercase ascii
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        begin
            if (d < 4'd10)
            begin
                c = 8'h30 + {4'b0, d};
            end
            else
            begin
                c = 8'h37 + {4'b0, d};
            end
            return c;
        end
    endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter_unit.sv =====
// path: request queue, back end sequencer, registered character output
// the back end finishes one request before it takes the next; for decimal it converts
// 4 bits per cycle into bcd
// the request queue lets the next request be taken while the back end works
// reset: asynchronous active low, empties the queue, idles the sequencer and
// drops the output valid; no storage clearing pass
module integer_to_ascii_formatter_unit #(
    parameter int unsigned QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], character [39:32]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char [7:0]
    output logic        m_tlast
);
    import itoa_pkg::*;

    fmt_req_t  push_data;
    fmt_req_t  pop_data;
    logic      push;
    logic      full;
    logic      pop_valid;
    logic      pop;

    // classify incoming requests
    itoa_front u_front (
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .mode      (s_tuser),
        .value     (s_tdata[31:0]),
        .character (s_tdata[39:32]),
        .q_full    (full),
        .q_push    (push),
        .q_data    (push_data)
    );

    // decoupling queue
    itoa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop)
    );

    // conversion and character emission
    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_data    (pop_data),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== rtl/itoa_front.sv =====
module itoa_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            mode,
    input  logic [31:0]           value,
    input  logic [7:0]            character,
    input  logic                  q_full,
    output logic                  q_push,
    output itoa_pkg::fmt_req_t    q_data
);
    import itoa_pkg::*;

    // take a request whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // classify the request and take the magnitude of a negative signed value
    always_comb
    begin
        q_data.ch   = character;
        q_data.neg  = 1'b0;
        q_data.mag  = value;
        q_data.kind = K_LIT;
        unique case (mode)
            MODE_LITERAL:
            begin
                q_data.kind = K_LIT;
            end
            MODE_SIGNED:
            begin
                q_data.kind = K_DEC;
                q_data.neg  = value[VALUE_W-1];
                if (value[VALUE_W-1])
                begin
                    q_data.mag = 32'd0 - value;
                end
            end
            MODE_UNSIGNED:
            begin
                q_data.kind = K_DEC;
            end
            MODE_HEX:
            begin
                q_data.kind = K_HEX;
            end
            default:
            begin
                q_data.kind = K_LIT;
            end
        endcase
    end

endmodule

// ===== rtl/itoa_queue.sv =====
module itoa_queue #(
    parameter int unsigned DEPTH = itoa_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  itoa_pkg::fmt_req_t    push_data,
    output logic                  full,
    output logic                  pop_valid,
    output itoa_pkg::fmt_req_t    pop_data,
    input  logic                  pop
);
    import itoa_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    fmt_req_t          entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && pop_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(pop && pop_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && pop_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

endmodule

// ===== rtl/itoa_back.sv =====
module itoa_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  itoa_pkg::fmt_req_t    q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_char,
    output logic                  out_last
);
    import itoa_pkg::*;

    back_state_t         state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [2:0]          step_reg, step_next;
    logic [3:0]          pos_reg, pos_next;
    logic [1:0]          pre_reg, pre_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;

    logic                adv;
    logic                emit;
    logic [BCD_W-1:0]    conv_bcd;
    logic [3:0]          top_pos;
    logic [3:0]          cur_digit;

    // one shift-add-3 step of binary to bcd conversion
    function automatic logic [BCD_W-1:0] dd_bit(input logic [BCD_W-1:0] b,
                                                input logic in_bit);
        logic [BCD_W-1:0] a;
        begin
            a = b;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (a[i*4 +: 4] >= 4'd5)
                begin
                    a[i*4 +: 4] = a[i*4 +: 4] + 4'd3;
                end
            end
            return {a[BCD_W-2:0], in_bit};
        end
    endfunction

    assign adv       = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    // four conversion bits per cycle
    always_comb
    begin
        conv_bcd = bcd_reg;
        for (int k = 0; k < BITS_STEP; k++)
        begin
            conv_bcd = dd_bit(conv_bcd, bin_reg[VALUE_W-1-k]);
        end
    end

    // highest non-zero digit, zero when the number is zero
    always_comb
    begin
        top_pos = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                top_pos = 4'(i);
            end
        end
    end

    assign cur_digit = 4'(bcd_reg >> {pos_reg, 2'b00});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_data.kind)
                        K_DEC:   state_next = B_CONV;
                        K_HEX:   state_next = B_SCAN;
                        default: state_next = B_LIT;
                    endcase
                end
            end
            B_CONV:
            begin
                if (step_reg == 3'(CONV_STEPS - 1))
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (kind_reg == K_HEX || neg_reg)
                begin
                    state_next = B_PRE;
                end
                else
                begin
                    state_next = B_DIG;
                end
            end
            B_PRE:
            begin
                if (adv && pre_reg == 2'd1)
                begin
                    state_next = B_DIG;
                end
            end
            B_DIG:
            begin
                if (adv && pos_reg == 4'd0)
                begin
                    state_next = B_IDLE;
                end
            end
            B_LIT:
            begin
                if (adv)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        q_pop          = 1'b0;
        emit           = 1'b0;
        kind_next      = kind_reg;
        neg_next       = neg_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        pre_next       = pre_reg;
        ch_next        = ch_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                q_pop     = q_valid;
                kind_next = q_data.kind;
                neg_next  = q_data.neg;
                ch_next   = q_data.ch;
                bin_next  = q_data.mag;
                step_next = 3'd0;
                if (q_data.kind == K_HEX)
                begin
                    bcd_next = BCD_W'(q_data.mag);
                end
                else
                begin
                    bcd_next = '0;
                end
            end
            B_CONV:
            begin
                bcd_next  = conv_bcd;
                bin_next  = {bin_reg[VALUE_W-BITS_STEP-1:0], {BITS_STEP{1'b0}}};
                step_next = step_reg + 1'b1;
            end
            B_SCAN:
            begin
                pos_next = top_pos;
                pre_next = (kind_reg == K_HEX) ? 2'd2 : {1'b0, neg_reg};
            end
            B_PRE:
            begin
                if (adv)
                begin
                    emit          = 1'b1;
                    out_last_next = 1'b0;
                    pre_next      = pre_reg - 1'b1;
                    if (kind_reg == K_HEX)
                    begin
                        out_char_next = (pre_reg == 2'd2) ? CH_ZERO : CH_X;
                    end
                    else
                    begin
                        out_char_next = CH_MINUS;
                    end
                end
            end
            B_DIG:
            begin
                if (adv)
                begin
                    emit          = 1'b1;
                    out_char_next = digit_char(cur_digit);
                    out_last_next = (pos_reg == 4'd0);
                    pos_next      = pos_reg - 1'b1;
                end
            end
            B_LIT:
            begin
                if (adv)
                begin
                    emit          = 1'b1;
                    out_char_next = ch_reg;
                    out_last_next = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
        out_valid_next = emit || (out_valid_reg && !out_ready);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        neg_reg      <= neg_next;
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        step_reg     <= step_next;
        pos_reg      <= pos_next;
        pre_reg      <= pre_next;
        ch_reg       <= ch_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // the final character of a request returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_last_next) |=> (state_reg == B_IDLE))
        else $error("last character not followed by idle");

    // a new request is only taken when the previous one is finished
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == B_IDLE))
        else $error("request popped while busy");

    // digit position stays inside the bcd word while emitting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIG) |-> (pos_reg < 4'(NUM_DIGITS)))
        else $error("digit position out of range");

    // prefix state always has a prefix character left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PRE) |-> (pre_reg != 2'd0))
        else $error("prefix state with empty prefix count");

endmodule
